// ===== hdl/dmxmap_pkg.sv =====
// ----------------------------------------------------------------------------
// dmxmap_pkg
// Shared constants, register codes and item types of the universe mapper.
// ----------------------------------------------------------------------------
package dmxmap_pkg;

  localparam int NUM_UNIVERSES = 16;
  localparam int SLOTS_MAX     = 512;
  localparam int BUFFER_BYTES  = 8192;

  localparam int IDX_W = (NUM_UNIVERSES > 1) ? $clog2(NUM_UNIVERSES) : 1;

  // field widths
  localparam int SU_W   = 15;
  localparam int PER_W  = 10;
  localparam int FC_W   = 10;
  localparam int BS_W   = 14;
  localparam int UNI_W  = 15;
  localparam int SEQ_W  = 8;
  localparam int LEN_W  = 10;
  localparam int SLOT_W = 9;
  localparam int DATA_W = 8;
  localparam int ADDR_W = 13;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 15;

  // universe index times slots per universe
  localparam int PROD_W = IDX_W + PER_W;
  // working width for window arithmetic, holds the span and the product
  localparam int MATH_W = (PROD_W > BS_W + 1) ? PROD_W : BS_W + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    REG_START_UNIVERSE = 2'd0,
    REG_CHANNELS_PER   = 2'd1,
    REG_FIRST_CHANNEL  = 2'd2,
    REG_BUFFER_SIZE    = 2'd3
  } cfg_reg_e;

  localparam logic [SU_W-1:0]  START_UNIVERSE_RST = SU_W'(1);
  localparam logic [PER_W-1:0] CHANNELS_PER_RST   = PER_W'(SLOTS_MAX);
  localparam logic [FC_W-1:0]  FIRST_CHANNEL_RST  = FC_W'(1);
  localparam logic [BS_W-1:0]  BUFFER_SIZE_RST    = BS_W'(0);

  typedef struct packed {
    logic [SU_W-1:0]  start_universe;
    logic [PER_W-1:0] channels_per_universe;
    logic [FC_W-1:0]  first_channel;
    logic [BS_W-1:0]  buffer_size;
  } cfg_t;

  typedef struct packed {
    logic [UNI_W-1:0]  universe_id;
    logic [SEQ_W-1:0]  sequence_req;
    logic [LEN_W-1:0]  frame_length;
    logic [SLOT_W-1:0] slot_index;
    logic [DATA_W-1:0] slot_data;
    logic              first_of_frame;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              write_valid;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
    logic              sequence_error;
    logic [CNT_W-1:0]  universe_errors;
    logic [CNT_W-1:0]  universe_packets;
    logic [CNT_W-1:0]  total_packets;
    logic [CNT_W-1:0]  total_errors;
  } out_item_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic              first_of_frame;
    logic [SEQ_W-1:0]  sequence_req;
    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic              write_valid;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
  } q_item_t;

endpackage

// ===== hdl/dmxmap_in_if.sv =====
// ----------------------------------------------------------------------------
// dmxmap_in_if
// Slot input channel: valid/ready handshake with a slot item payload.
// ----------------------------------------------------------------------------
interface dmxmap_in_if;
  logic                 valid;
  logic                 ready;
  dmxmap_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/dmxmap_out_if.sv =====
// ----------------------------------------------------------------------------
// dmxmap_out_if
// Result output channel: valid/ready handshake with a result item payload.
// ----------------------------------------------------------------------------
interface dmxmap_out_if;
  logic                  valid;
  logic                  ready;
  dmxmap_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/dmxmap_cfg.sv =====
// ----------------------------------------------------------------------------
// dmxmap_cfg
// Configuration registers; every write re-clamps the whole register set.
// ----------------------------------------------------------------------------
module dmxmap_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [1:0]                     idx_i,
  input  logic [dmxmap_pkg::CFG_W-1:0]   data_i,
  output dmxmap_pkg::cfg_t               cfg_o
);

  dmxmap_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    dmxmap_pkg::cfg_t raw;
    raw = cfg_q;
    unique case (dmxmap_pkg::cfg_reg_e'(idx_i))
      dmxmap_pkg::REG_START_UNIVERSE: raw.start_universe = data_i[dmxmap_pkg::SU_W-1:0];
      dmxmap_pkg::REG_CHANNELS_PER:   raw.channels_per_universe = data_i[dmxmap_pkg::PER_W-1:0];
      dmxmap_pkg::REG_FIRST_CHANNEL:  raw.first_channel = data_i[dmxmap_pkg::FC_W-1:0];
      dmxmap_pkg::REG_BUFFER_SIZE:    raw.buffer_size = data_i[dmxmap_pkg::BS_W-1:0];
    endcase

    if (raw.start_universe == '0) begin
      raw.start_universe = dmxmap_pkg::SU_W'(1);
    end
    if (raw.channels_per_universe == '0 ||
        raw.channels_per_universe > dmxmap_pkg::PER_W'(dmxmap_pkg::SLOTS_MAX)) begin
      raw.channels_per_universe = dmxmap_pkg::PER_W'(dmxmap_pkg::SLOTS_MAX);
    end
    // first channel past the universe falls back one below its end
    if (raw.first_channel == '0) begin
      raw.first_channel = dmxmap_pkg::FC_W'(1);
    end else if (raw.first_channel > raw.channels_per_universe) begin
      if (raw.channels_per_universe > dmxmap_pkg::PER_W'(1)) begin
        raw.first_channel = raw.channels_per_universe - dmxmap_pkg::PER_W'(1);
      end else begin
        raw.first_channel = dmxmap_pkg::FC_W'(1);
      end
    end
    if (raw.buffer_size > dmxmap_pkg::BS_W'(dmxmap_pkg::BUFFER_BYTES)) begin
      raw.buffer_size = dmxmap_pkg::BS_W'(dmxmap_pkg::BUFFER_BYTES);
    end

    cfg_d = we_i ? raw : cfg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_universe        <= dmxmap_pkg::START_UNIVERSE_RST;
      cfg_q.channels_per_universe <= dmxmap_pkg::CHANNELS_PER_RST;
      cfg_q.first_channel         <= dmxmap_pkg::FIRST_CHANNEL_RST;
      cfg_q.buffer_size           <= dmxmap_pkg::BUFFER_SIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/dmxmap_front.sv =====
// ----------------------------------------------------------------------------
// dmxmap_front
// Three-stage classifier: universe index, mapped window and buffer address.
// ----------------------------------------------------------------------------
module dmxmap_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dmxmap_in_if.sink             slot_i,
  input  dmxmap_pkg::cfg_t      cfg_i,
  output logic                  q_valid_o,
  output dmxmap_pkg::q_item_t   q_item_o,
  input  logic                  q_ready_i
);

  localparam int MW = dmxmap_pkg::MATH_W;
  localparam int IW = dmxmap_pkg::IDX_W;

  // stage 1: universe offset and product with slots per universe
  logic                                v1_q;
  dmxmap_pkg::in_item_t                p1_q;
  logic [IW-1:0]                       idx1_q;
  logic                                tab1_q;
  logic [dmxmap_pkg::PROD_W-1:0]       prod1_q;

  // stage 2: range check and window of the universe entry
  logic                                v2_q;
  dmxmap_pkg::in_item_t                p2_q;
  logic [IW-1:0]                       idx2_q;
  logic                                rng2_q;
  logic [dmxmap_pkg::SLOT_W-1:0]       src2_q;
  logic [dmxmap_pkg::BS_W-1:0]         dest2_q;
  logic [dmxmap_pkg::PER_W-1:0]        per2_q;

  // stage 3: slot offset and byte count of the entry
  logic                                v3_q;
  dmxmap_pkg::in_item_t                p3_q;
  logic [IW-1:0]                       idx3_q;
  logic                                rng3_q;
  logic                                ge3_q;
  logic [dmxmap_pkg::SLOT_W-1:0]       off3_q;
  logic [dmxmap_pkg::PER_W-1:0]        cnt3_q;
  logic [dmxmap_pkg::BS_W-1:0]         dest3_q;

  logic en1, en2, en3;

  assign en3 = !v3_q || q_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign slot_i.ready = en1;

  // stage 1 logic
  logic [dmxmap_pkg::SU_W:0]     diff;
  logic                          tab_ok;
  logic [dmxmap_pkg::PROD_W-1:0] prod;

  assign diff   = {1'b0, slot_i.payload.universe_id} - {1'b0, cfg_i.start_universe};
  assign tab_ok = !diff[dmxmap_pkg::SU_W] &&
                  (diff[dmxmap_pkg::SU_W-1:0] < dmxmap_pkg::SU_W'(dmxmap_pkg::NUM_UNIVERSES));
  assign prod   = dmxmap_pkg::PROD_W'(diff[IW-1:0]) *
                  dmxmap_pkg::PROD_W'(cfg_i.channels_per_universe);

  // stage 2 logic
  logic [MW-1:0]                 span;
  logic [dmxmap_pkg::FC_W-1:0]   fc0;
  logic                          is_first_entry;
  logic [MW-1:0]                 cap;
  logic [dmxmap_pkg::BS_W-1:0]   dest;
  logic [dmxmap_pkg::PER_W-1:0]  per_e;
  logic [dmxmap_pkg::SLOT_W-1:0] src;

  assign span = MW'(cfg_i.first_channel) + MW'(cfg_i.buffer_size) - MW'(1);
  assign fc0  = cfg_i.first_channel - dmxmap_pkg::FC_W'(1);
  assign is_first_entry = (idx1_q == '0);
  // later entries begin where the bytes of earlier entries end, capped at the buffer
  assign cap  = MW'(prod1_q) - MW'(fc0);
  assign dest = is_first_entry ? '0 :
                (cap < MW'(cfg_i.buffer_size)) ? cap[dmxmap_pkg::BS_W-1:0] : cfg_i.buffer_size;
  assign per_e = is_first_entry ? cfg_i.channels_per_universe - fc0
                                : cfg_i.channels_per_universe;
  assign src  = is_first_entry ? fc0[dmxmap_pkg::SLOT_W-1:0] : '0;

  // stage 3 logic
  logic [dmxmap_pkg::BS_W-1:0]   left;
  logic [dmxmap_pkg::PER_W-1:0]  cnt;

  assign left = cfg_i.buffer_size - dest2_q;
  assign cnt  = (dmxmap_pkg::BS_W'(per2_q) < left) ? per2_q : left[dmxmap_pkg::PER_W-1:0];

  // output of stage 3
  logic wv;

  assign wv = ge3_q &&
              (dmxmap_pkg::PER_W'(off3_q) < cnt3_q) &&
              (dmxmap_pkg::LEN_W'(off3_q) < p3_q.frame_length);

  assign q_valid_o                = v3_q;
  assign q_item_o.first_of_frame  = p3_q.first_of_frame;
  assign q_item_o.sequence_req    = p3_q.sequence_req;
  assign q_item_o.idx             = idx3_q;
  assign q_item_o.in_range        = rng3_q;
  assign q_item_o.write_valid     = wv;
  assign q_item_o.write_address   = dmxmap_pkg::ADDR_W'(dest3_q + dmxmap_pkg::BS_W'(off3_q));
  assign q_item_o.write_data      = p3_q.slot_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= slot_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p1_q    <= slot_i.payload;
      idx1_q  <= diff[IW-1:0];
      tab1_q  <= tab_ok;
      prod1_q <= prod;
    end
    if (en2) begin
      p2_q    <= p1_q;
      idx2_q  <= idx1_q;
      rng2_q  <= tab1_q && (MW'(prod1_q) < span);
      src2_q  <= src;
      dest2_q <= dest;
      per2_q  <= per_e;
    end
    if (en3) begin
      p3_q    <= p2_q;
      idx3_q  <= idx2_q;
      rng3_q  <= rng2_q;
      ge3_q   <= (p2_q.slot_index >= src2_q);
      off3_q  <= p2_q.slot_index - src2_q;
      cnt3_q  <= cnt;
      dest3_q <= dest2_q;
    end
  end

endmodule

// ===== hdl/dmxmap_queue.sv =====
// ----------------------------------------------------------------------------
// dmxmap_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module dmxmap_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  input  dmxmap_pkg::q_item_t   push_item_i,
  output logic                  push_ready_o,
  output logic                  pop_valid_o,
  output dmxmap_pkg::q_item_t   pop_item_o,
  input  logic                  pop_ready_i
);

  localparam int PW = dmxmap_pkg::QPTR_W;

  dmxmap_pkg::q_item_t mem_q [dmxmap_pkg::QUEUE_DEPTH];
  logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [PW:0]         fill_q;
  logic                push, pop;

  assign push_ready_o = (fill_q != (PW+1)'(dmxmap_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PW'(dmxmap_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(dmxmap_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      if (push && !pop)      fill_q <= fill_q + (PW+1)'(1);
      else if (pop && !push) fill_q <= fill_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_item_i;
  end

endmodule

// ===== hdl/dmxmap_back.sv =====
// ----------------------------------------------------------------------------
// dmxmap_back
// Sequence check, packet and error counters, and the result register.
// ----------------------------------------------------------------------------
module dmxmap_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  dmxmap_pkg::q_item_t   q_item_i,
  output logic                  q_ready_o,
  dmxmap_out_if.source          result_o
);

  localparam int CW = dmxmap_pkg::CNT_W;

  logic [dmxmap_pkg::SEQ_W-1:0] exp_q [dmxmap_pkg::NUM_UNIVERSES];
  logic [CW-1:0]                err_q [dmxmap_pkg::NUM_UNIVERSES];
  logic [CW-1:0]                pkt_q [dmxmap_pkg::NUM_UNIVERSES];
  logic [CW-1:0]                pkt_tot_q, err_tot_q;
  logic                         frame_ok_q;
  logic                         out_valid_q;
  dmxmap_pkg::out_item_t        out_q, out_d;

  logic          out_en, pop, hit, serr, ok, wr;
  logic [CW-1:0] uerr, upkt, uerr_n, upkt_n, pkt_tot_n, err_tot_n;

  assign out_en    = !out_valid_q || result_o.ready;
  assign pop       = q_valid_i && out_en;
  assign q_ready_o = out_en;

  // header checks only on a frame's first slot
  assign hit  = q_item_i.first_of_frame && q_item_i.in_range;
  assign serr = hit && (exp_q[q_item_i.idx] != q_item_i.sequence_req);
  assign ok   = q_item_i.first_of_frame ? q_item_i.in_range : (q_item_i.in_range && frame_ok_q);
  assign wr   = ok && q_item_i.write_valid;

  assign uerr      = err_q[q_item_i.idx];
  assign upkt      = pkt_q[q_item_i.idx];
  assign uerr_n    = uerr + CW'(serr);
  assign upkt_n    = upkt + CW'(hit);
  assign pkt_tot_n = pkt_tot_q + CW'(hit);
  assign err_tot_n = err_tot_q + CW'(serr);

  always_comb begin
    out_d.accepted         = ok;
    out_d.write_valid      = wr;
    out_d.write_address    = wr ? q_item_i.write_address : '0;
    out_d.write_data       = wr ? q_item_i.write_data : '0;
    out_d.sequence_error   = serr;
    out_d.universe_errors  = ok ? uerr_n : '0;
    out_d.universe_packets = ok ? upkt_n : '0;
    out_d.total_packets    = pkt_tot_n;
    out_d.total_errors     = err_tot_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dmxmap_pkg::NUM_UNIVERSES; i++) begin
        exp_q[i] <= '0;
        err_q[i] <= '0;
        pkt_q[i] <= '0;
      end
      pkt_tot_q   <= '0;
      err_tot_q   <= '0;
      frame_ok_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_en) out_valid_q <= q_valid_i;
      if (pop) begin
        if (q_item_i.first_of_frame) frame_ok_q <= q_item_i.in_range;
        if (hit) begin
          // matched or adopted, the next expected value is received plus one
          exp_q[q_item_i.idx] <= q_item_i.sequence_req + dmxmap_pkg::SEQ_W'(1);
          err_q[q_item_i.idx] <= uerr_n;
          pkt_q[q_item_i.idx] <= upkt_n;
        end
        pkt_tot_q <= pkt_tot_n;
        err_tot_q <= err_tot_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) out_q <= out_d;
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

endmodule

// ===== hdl/dmx_universe_to_buffer_mapper.sv =====
// ----------------------------------------------------------------------------
// dmx_universe_to_buffer_mapper
// Maps slot bytes of lighting-universe frames into a flat channel buffer.
// ----------------------------------------------------------------------------
// Path: an accepted item passes three classifier stages, one queue slot and
// the result register.
// Throughput: one item per cycle while results are taken; the result register
// and a 4-deep queue decouple the two sides.
// Reset: configuration to its defaults, counters and expected sequences to
// zero, at once; no clearing pass.
module dmx_universe_to_buffer_mapper (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dmxmap_in_if.sink                    slot_i,
  dmxmap_out_if.source                 result_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [dmxmap_pkg::CFG_W-1:0] cfg_data_i
);

  dmxmap_pkg::cfg_t    cfg;
  logic                f_valid, f_ready, b_valid, b_ready;
  dmxmap_pkg::q_item_t f_item, b_item;

  dmxmap_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  dmxmap_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .slot_i    (slot_i),
    .cfg_i     (cfg),
    .q_valid_o (f_valid),
    .q_item_o  (f_item),
    .q_ready_i (f_ready)
  );

  dmxmap_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_item_i  (f_item),
    .push_ready_o (f_ready),
    .pop_valid_o  (b_valid),
    .pop_item_o   (b_item),
    .pop_ready_i  (b_ready)
  );

  dmxmap_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (b_valid),
    .q_item_i  (b_item),
    .q_ready_o (b_ready),
    .result_o  (result_o)
  );

  a_write_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.payload.write_valid |-> result_o.payload.accepted)
    else $error("buffer write on a slot that was not accepted");

  a_seqerr_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.payload.sequence_error |-> result_o.payload.accepted)
    else $error("sequence error on a frame that was not accepted");

  a_rejected_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.payload.accepted |->
      result_o.payload.universe_errors == '0 && result_o.payload.universe_packets == '0)
    else $error("universe counters shown for a rejected slot");

  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.payload.write_valid |->
      result_o.payload.write_address == '0 && result_o.payload.write_data == '0)
    else $error("address or data shown without a buffer write");

endmodule

// ===== dv/dmxmap_slot_checker.sv =====
// ----------------------------------------------------------------------------
// dmxmap_slot_checker
// Watches the slot and result channels and the register port of the universe
// mapper, works out the result of every accepted slot item from its own copy
// of the configuration, window table and counters, and compares each result
// item field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module dmxmap_slot_checker
  import dmxmap_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  dmxmap_in_if             slot_i,
  dmxmap_out_if            result_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  localparam int unsigned MAX_REPORTS = 10;

  // configuration as held after clamping
  int unsigned start_uni;
  int unsigned slots_per_uni;
  int unsigned first_chan;
  int unsigned buf_size;
  int unsigned last_uni;

  int unsigned win_src  [NUM_UNIVERSES];
  int unsigned win_dest [NUM_UNIVERSES];
  int unsigned win_len  [NUM_UNIVERSES];

  logic [SEQ_W-1:0] next_seq [NUM_UNIVERSES];
  logic [CNT_W-1:0] uni_errs [NUM_UNIVERSES];
  logic [CNT_W-1:0] uni_pkts [NUM_UNIVERSES];
  logic [CNT_W-1:0] pkt_total;
  logic [CNT_W-1:0] err_total;
  bit               frame_open;

  out_item_t mapped_slots_q [$];

  function automatic void rebuild_window_table();
    int unsigned span;
    int unsigned src;
    int unsigned dest;
    int unsigned left;
    int unsigned room;
    int unsigned n;
    if (start_uni < 1) start_uni = 1;
    if (slots_per_uni < 1 || slots_per_uni > SLOTS_MAX) slots_per_uni = SLOTS_MAX;
    if (first_chan < 1) begin
      first_chan = 1;
    end else if (first_chan > slots_per_uni) begin
      first_chan = slots_per_uni - 1;
      if (first_chan < 1) first_chan = 1;
    end
    if (buf_size > BUFFER_BYTES) buf_size = BUFFER_BYTES;

    span     = first_chan + buf_size - 1;
    last_uni = (start_uni + (span + slots_per_uni - 1) / slots_per_uni - 1) & 32'hFFFF;

    // first universe starts mid-frame, the rest take whole universes
    src  = first_chan - 1;
    dest = 0;
    left = buf_size;
    room = slots_per_uni - src;
    for (int i = 0; i < NUM_UNIVERSES; i++) begin
      n           = (room < left) ? room : left;
      win_src[i]  = src;
      win_dest[i] = dest;
      win_len[i]  = n;
      dest        = dest + n;
      left        = left - n;
      room        = slots_per_uni;
      src         = 0;
    end
  endfunction

  function automatic void reset_mapper_model();
    start_uni     = START_UNIVERSE_RST;
    slots_per_uni = CHANNELS_PER_RST;
    first_chan    = FIRST_CHANNEL_RST;
    buf_size      = BUFFER_SIZE_RST;
    for (int i = 0; i < NUM_UNIVERSES; i++) begin
      next_seq[i] = '0;
      uni_errs[i] = '0;
      uni_pkts[i] = '0;
    end
    pkt_total  = '0;
    err_total  = '0;
    frame_open = 1'b0;
    rebuild_window_table();
  endfunction

  function automatic void write_mapper_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_START_UNIVERSE: start_uni     = data[SU_W-1:0];
      REG_CHANNELS_PER:   slots_per_uni = data[PER_W-1:0];
      REG_FIRST_CHANNEL:  first_chan    = data[FC_W-1:0];
      REG_BUFFER_SIZE:    buf_size      = data[BS_W-1:0];
      default: ;
    endcase
    rebuild_window_table();
  endfunction

  function automatic out_item_t map_slot(input in_item_t it);
    out_item_t   r;
    int unsigned u;
    int unsigned idx;
    int unsigned slot;
    int unsigned cnt;
    int unsigned src;
    bit          ok;
    r    = '0;
    u    = it.universe_id;
    slot = it.slot_index;
    ok   = (u >= start_uni) && (u <= last_uni) && (u - start_uni < NUM_UNIVERSES);
    idx  = ok ? u - start_uni : 0;

    if (it.first_of_frame) begin
      frame_open = ok;
      if (ok) begin
        if (next_seq[idx] != it.sequence_req) begin
          r.sequence_error = 1'b1;
          uni_errs[idx]    = uni_errs[idx] + 1;
          err_total        = err_total + 1;
          next_seq[idx]    = it.sequence_req;
        end
        next_seq[idx] = next_seq[idx] + 1'b1;
        uni_pkts[idx] = uni_pkts[idx] + 1;
        pkt_total     = pkt_total + 1;
      end
    end else begin
      ok = ok && frame_open;
    end

    if (ok) begin
      cnt = (win_len[idx] < it.frame_length) ? win_len[idx] : it.frame_length;
      src = win_src[idx];
      if (slot >= src && slot - src < cnt) begin
        r.write_valid   = 1'b1;
        r.write_address = ADDR_W'(win_dest[idx] + slot - src);
        r.write_data    = it.slot_data;
      end
      r.universe_errors  = uni_errs[idx];
      r.universe_packets = uni_pkts[idx];
    end
    r.accepted      = ok;
    r.total_packets = pkt_total;
    r.total_errors  = err_total;
    return r;
  endfunction

  function automatic string format_result(input out_item_t r);
    return $sformatf("acc=%0b wv=%0b addr=%0d data=%0h serr=%0b uerr=%0d upkt=%0d tpkt=%0d terr=%0d",
                     r.accepted, r.write_valid, r.write_address, r.write_data,
                     r.sequence_error, r.universe_errors, r.universe_packets,
                     r.total_packets, r.total_errors);
  endfunction

  function automatic void check_result(input out_item_t want, input out_item_t got);
    if (got.accepted !== want.accepted || got.write_valid !== want.write_valid ||
        got.write_address !== want.write_address || got.write_data !== want.write_data ||
        got.sequence_error !== want.sequence_error ||
        got.universe_errors !== want.universe_errors ||
        got.universe_packets !== want.universe_packets ||
        got.total_packets !== want.total_packets ||
        got.total_errors !== want.total_errors) begin
      fail_count_o = fail_count_o + 1;
      if (fail_count_o <= MAX_REPORTS) begin
        $display("result mismatch at %0t", $realtime);
        $display("  expected %s", format_result(want));
        $display("  actual   %s", format_result(got));
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_mapper_model();
      mapped_slots_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) write_mapper_reg(cfg_idx_i, cfg_data_i);
      if (slot_i.valid && slot_i.ready) mapped_slots_q.push_back(map_slot(slot_i.payload));
      if (result_i.valid && result_i.ready) begin
        if (mapped_slots_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= MAX_REPORTS)
            $display("result item with none outstanding: %s", format_result(result_i.payload));
        end else begin
          check_result(mapped_slots_q.pop_front(), result_i.payload);
        end
      end
      pending_o = mapped_slots_q.size();
    end
  end

endmodule

// ===== dv/dmx_universe_to_buffer_mapper_test.sv =====
// ----------------------------------------------------------------------------
// dmx_universe_to_buffer_mapper_test
// Drives slot items and register writes into the universe mapper with random
// gaps on both channels, a receiver hold-off and drained phases between
// configurations. The slot checker predicts and compares every result item;
// this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module dmx_universe_to_buffer_mapper_test;
  import dmxmap_pkg::*;

  localparam int          CLK_PERIOD   = 4;
  localparam int          RESET_CYCLES = 10;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned HOLD_CYCLES  = 100;
  localparam int unsigned SETTLE       = 20;
  localparam int unsigned LIMIT_CYCLES = 400000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_pct   = 31;
  int unsigned hold_ask   = 0;
  int unsigned hold_done  = 0;
  int unsigned sent_items = 0;

  // register values last written, used only to aim the stimulus
  int unsigned cur_su  = 1;
  int unsigned cur_per = 512;
  int unsigned cur_fc  = 1;

  // sequence each universe should carry next, as far as we have sent
  bit [SEQ_W-1:0] seq_guess [0:32767];

  dmxmap_in_if  slot_ch ();
  dmxmap_out_if result_ch ();

  dmx_universe_to_buffer_mapper i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .slot_i     (slot_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  dmxmap_slot_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slot_i       (slot_ch),
    .result_i     (result_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic send_slot(input logic [UNI_W-1:0] u, input logic [SEQ_W-1:0] seq,
                           input logic [LEN_W-1:0] len, input logic [SLOT_W-1:0] slot,
                           input logic [DATA_W-1:0] data, input logic first);
    in_item_t it;
    it.universe_id    = u;
    it.sequence_req   = seq;
    it.frame_length   = len;
    it.slot_index     = slot;
    it.slot_data      = data;
    it.first_of_frame = first;
    while ($urandom_range(99) < idle_pct) begin
      slot_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    slot_ch.valid   <= 1'b1;
    slot_ch.payload <= it;
    @(posedge clk_i);
    while (!slot_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent_items++;
  endtask

  // stop offering and wait for every outstanding result item
  task automatic drain();
    slot_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic load_config(input logic [CFG_W-1:0] su, input logic [CFG_W-1:0] per,
                             input logic [CFG_W-1:0] fc, input logic [CFG_W-1:0] bs,
                             input int unsigned rot);
    logic [CFG_W-1:0] v [4];
    int unsigned      k;
    int unsigned      r;
    v[0] = su;
    v[1] = per;
    v[2] = fc;
    v[3] = bs;
    drain();
    for (k = 0; k < 4; k++) begin
      r         = (k + rot) % 4;
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_reg_e'(r);
      cfg_data <= v[r];
      @(negedge clk_i);
    end
    cfg_we  <= 1'b0;
    cur_su  = su[SU_W-1:0];
    cur_per = per[PER_W-1:0];
    cur_fc  = fc[FC_W-1:0];
  endtask

  task automatic send_frame(input bit broken);
    int unsigned    u;
    int unsigned    len;
    int unsigned    s0;
    int unsigned    n;
    int unsigned    pick;
    int unsigned    base;
    int unsigned    per_eff;
    int unsigned    fc_eff;
    int unsigned    k;
    int             t;
    logic [UNI_W-1:0] uid;
    logic [SEQ_W-1:0] seq;
    bit             first;
    base    = (cur_su == 0) ? 1 : cur_su;
    per_eff = (cur_per == 0 || cur_per > SLOTS_MAX) ? SLOTS_MAX : cur_per;
    fc_eff  = (cur_fc == 0) ? 1 :
              (cur_fc > per_eff) ? ((per_eff > 1) ? per_eff - 1 : 1) : cur_fc;

    pick = $urandom_range(99);
    if (pick < 78)      u = base + $urandom_range(0, 17);
    else if (pick < 88) u = (base > 3) ? base - $urandom_range(1, 3) : 0;
    else                u = $urandom_range(0, 32767);
    if (u > 32767) u = 32767 - $urandom_range(0, 3);

    pick = $urandom_range(99);
    if (pick < 30) begin
      s0 = 0;
    end else if (pick < 50) begin
      t = int'(fc_eff) - 3 + int'($urandom_range(0, 4));
      s0 = (t < 0) ? 0 : t;
    end else if (pick < 62) begin
      s0 = per_eff - $urandom_range(0, 3);
    end else begin
      s0 = $urandom_range(0, 511);
    end
    s0 = s0 % 512;

    n = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);

    pick = $urandom_range(99);
    if (pick < 30)      len = 512;
    else if (pick < 55) len = s0 + n - $urandom_range(0, n);
    else if (pick < 75) len = $urandom_range(0, 16);
    else                len = $urandom_range(0, 512);
    if (len > 512) len = 512;

    seq = ($urandom_range(99) < 85) ? seq_guess[u] : SEQ_W'($urandom_range(0, 255));
    seq_guess[u] = seq + 1'b1;

    for (k = 0; k < n; k++) begin
      uid   = UNI_W'(u);
      first = (k == 0);
      if (broken) begin
        // frame without its first slot, or a slot from another universe
        if (k == 0 && $urandom_range(1) == 1) first = 1'b0;
        else if (k > 0 && $urandom_range(3) == 0) uid = UNI_W'(u + $urandom_range(1, 2));
      end
      send_slot(uid, (k == 0) ? seq : SEQ_W'($urandom_range(0, 255)), LEN_W'(len),
                SLOT_W'((s0 + k) % 512), DATA_W'($urandom_range(0, 255)), first);
    end
  endtask

  // result side: random back-pressure, long hold-off on request
  initial begin : result_sink
    result_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_ask != hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_done = hold_ask;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      goal;
    int unsigned      base_count;
    int unsigned      pick;
    logic [CFG_W-1:0] v_su;
    logic [CFG_W-1:0] v_per;
    logic [CFG_W-1:0] v_fc;
    logic [CFG_W-1:0] v_bs;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_START_UNIVERSE;
    cfg_data        = '0;
    slot_ch.valid   = 1'b0;
    slot_ch.payload = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration: empty buffer, nothing accepted
    send_slot(15'd1, 8'd0, 10'd512, 9'd0, 8'hFF, 1'b1);
    send_slot(15'd0, 8'd255, 10'd0, 9'd511, 8'h00, 1'b1);

    // zero registers clamp up, oversize buffer clamps to the full 16 universes
    load_config(15'd0, 15'd0, 15'd0, 15'h3FFF, 0);
    send_slot(15'd1, 8'd0, 10'd512, 9'd0, 8'hA5, 1'b1);
    send_slot(15'd1, 8'd7, 10'd512, 9'd511, 8'h5A, 1'b0);
    send_slot(15'd1, 8'd0, 10'd10, 9'd10, 8'h11, 1'b0);   // past frame end
    send_slot(15'd1, 8'd0, 10'd512, 9'd5, 8'h22, 1'b1);   // sequence mismatch
    send_slot(15'd16, 8'd0, 10'd512, 9'd3, 8'h33, 1'b1);
    send_slot(15'd17, 8'd0, 10'd512, 9'd3, 8'h44, 1'b1);  // past last universe
    send_slot(15'd16, 8'd0, 10'd512, 9'd4, 8'h00, 1'b0);  // frame already rejected
    send_slot(15'd2, 8'd0, 10'd0, 9'd0, 8'h55, 1'b1);
    send_slot(15'd3, 8'd9, 10'd512, 9'd1, 8'h66, 1'b0);   // universe changes mid-frame

    // top universe, one slot per universe, first channel above the slot count
    load_config(15'd32767, 15'd1, 15'd600, 15'd8192, 0);
    send_slot(15'd32767, 8'd0, 10'd512, 9'd0, 8'hFF, 1'b1);
    send_slot(15'd32766, 8'd0, 10'd512, 9'd0, 8'h01, 1'b1);
    send_slot(15'd32767, 8'd3, 10'd512, 9'd1, 8'h02, 1'b0);

    // window starting on the last slot, slot count with junk high bits
    load_config(15'd10, 15'h7FFF, 15'd512, 15'd3, 0);
    send_slot(15'd10, 8'd0, 10'd512, 9'd511, 8'h81, 1'b1);
    send_slot(15'd11, 8'd0, 10'd512, 9'd1, 8'h82, 1'b1);
    send_slot(15'd11, 8'd0, 10'd512, 9'd2, 8'h83, 1'b0);

    // range reaches past the table: universe in range but without an entry
    load_config(15'd10, 15'd1, 15'd512, 15'd100, 0);
    send_slot(15'd30, 8'd0, 10'd512, 9'd0, 8'h91, 1'b1);
    send_slot(15'd25, 8'd0, 10'd512, 9'd0, 8'h92, 1'b1);
    send_slot(15'd10, 8'd3, 10'd512, 9'd0, 8'h93, 1'b1);

    base_count = sent_items;
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        load_config(15'd1, 15'd512, 15'd1, 15'd8192, 0);
      end else if (phase == 1) begin
        load_config(15'd100, 15'd3, 15'd5, 15'd20, 1);
      end else if (phase == 2) begin
        load_config(15'd32760, 15'd513, 15'd0, 15'd8193, 2);
      end else begin
        v_su = ($urandom_range(99) < 40) ? CFG_W'($urandom_range(0, 40))
                                         : CFG_W'($urandom_range(0, 32767));
        pick = $urandom_range(5);
        case (pick)
          0:       v_per = CFG_W'($urandom_range(0, 2));
          1:       v_per = CFG_W'($urandom_range(3, 8));
          2:       v_per = CFG_W'(SLOTS_MAX);
          3:       v_per = CFG_W'($urandom_range(513, 1023));
          default: v_per = CFG_W'($urandom_range(1, 512));
        endcase
        pick = $urandom_range(3);
        case (pick)
          0:       v_fc = CFG_W'($urandom_range(0, 1));
          1:       v_fc = CFG_W'($urandom_range(1, v_per + 3));
          default: v_fc = CFG_W'($urandom_range(0, 1023));
        endcase
        pick = $urandom_range(4);
        case (pick)
          0:       v_bs = CFG_W'($urandom_range(0, 40));
          1:       v_bs = CFG_W'(BUFFER_BYTES);
          2:       v_bs = CFG_W'($urandom_range(8193, 16383));
          default: v_bs = CFG_W'($urandom_range(0, 1200));
        endcase
        // bits above a register's width are ignored by the block
        if ($urandom_range(3) == 0) v_per = v_per | (CFG_W'($urandom_range(0, 31)) << PER_W);
        if ($urandom_range(3) == 0) v_fc = v_fc | (CFG_W'($urandom_range(0, 31)) << FC_W);
        if ($urandom_range(3) == 0) v_bs = v_bs | (CFG_W'($urandom_range(0, 1)) << BS_W);
        load_config(v_su, v_per, v_fc, v_bs, $urandom_range(0, 3));
      end

      idle_pct = (phase == 3) ? 0 : 31;
      if (phase == 5 || phase == 8) hold_ask++;

      goal = base_count + (phase + 1) * RANDOM_ITEMS / PHASES;
      while (sent_items < goal) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          send_slot(UNI_W'($urandom_range(0, 32767)), SEQ_W'($urandom_range(0, 255)),
                    LEN_W'($urandom_range(0, 512)), SLOT_W'($urandom_range(0, 511)),
                    DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          send_frame(pick < 16);
        end
      end
    end
    idle_pct = 31;

    drain();
    repeat (SETTLE) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

endmodule
